FILE: rtl/bir_pkg.sv
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types, sizes and codes of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bir_pkg;

  // frame store geometry
  localparam int MAX_ROWS      = 1024;
  localparam int MAX_COLS      = 1024;
  localparam int MAX_CHANNELS  = 3;
  localparam int FRACTION_BITS = 16;

  // field widths
  localparam int OP_W      = 1;
  localparam int ROW_W     = 10;
  localparam int COL_W     = 10;
  localparam int CH_W      = 2;
  localparam int PIX_W     = 8;
  localparam int SIZE_W    = 11;
  localparam int CHCNT_W   = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SIZE_W;

  // fixed point datapath (both axes share the ratio width)
  localparam int RATIO_W   = ROW_W + FRACTION_BITS;
  localparam int POS_W     = RATIO_W + ROW_W;
  localparam int INT_W     = POS_W - FRACTION_BITS;
  localparam int NB_W      = INT_W + 1;
  localparam int FW1_W     = FRACTION_BITS + 1;
  localparam int WGT_W     = 2 * FRACTION_BITS + 1;
  localparam int TERM_W    = WGT_W + PIX_W;
  localparam int SUM_W     = TERM_W + 1;
  localparam int VAL_W     = SUM_W - 2 * FRACTION_BITS;
  localparam int DIV_CNT_W = $clog2(RATIO_W);

  localparam int FRAME_DEPTH = MAX_ROWS * MAX_COLS * MAX_CHANNELS;
  localparam int FRAME_AW    = $clog2(FRAME_DEPTH);

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  // opcodes
  localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
  localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ROWS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COLS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] col_index;
    logic [CH_W-1:0]  channel_index;
    logic [PIX_W-1:0] pixel_in;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [CH_W-1:0]  out_channel;
  } result_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CH_W-1:0]  ch;
  } pos_t;

  // neighbour read order of one request
  typedef enum logic [1:0] {
    PH_TOP_LEFT,
    PH_TOP_RIGHT,
    PH_BOTTOM_LEFT,
    PH_BOTTOM_RIGHT
  } phase_t;

  // ratio divider sequencer
  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_LOAD_ROW,
    DIV_RUN_ROW,
    DIV_LOAD_COL,
    DIV_RUN_COL
  } div_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic col;
    logic busy;
  } div_ctrl_t;

  // byte address of (row, col, ch) in the frame store
  function automatic logic [FRAME_AW-1:0] frame_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col,
                                                     input logic [CH_W-1:0]  ch);
    logic [FRAME_AW-1:0] pix;
    pix = FRAME_AW'(row) * FRAME_AW'(MAX_COLS) + FRAME_AW'(col);
    return pix * FRAME_AW'(MAX_CHANNELS) + FRAME_AW'(ch);
  endfunction

endpackage

FILE: rtl/bilinear_image_resize.sv
// ----------------------------------------------------------------------------
// bilinear_image_resize
// Bilinear image scaler with a single-port source frame store.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+------------------------------
//  item     | in  | item_valid / item_stall   | item_t: load or pixel request
//  result   | out | result_valid/result_stall | result_t: interpolated byte
//  config   | in  | cfg_we                    | cfg_index, cfg_data
//
//  a load uses the frame memory port once, so loads run back to back
//  a request reads its four neighbours in turn on the single memory port
//  a result passes the front stage, the sequencer, the read return and the
//  interpolation stages before it enters the queue, and is offered from then on
//  a config write starts the ratio divider: items stall until both ratios are done
//  reset clears control only; frame contents are undefined until loaded
//  a four-entry result queue takes results while result_stall is high; with
//  four requests outstanding a fifth waits in the front stage and stalls items
//
module bilinear_image_resize
  import bir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0]  source_rows;
  logic [SIZE_W-1:0]  source_cols;
  logic [SIZE_W-1:0]  target_rows;
  logic [SIZE_W-1:0]  target_cols;
  logic [CHCNT_W-1:0] channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_rows   <= SIZE_W'(1);
      source_cols   <= SIZE_W'(1);
      target_rows   <= SIZE_W'(1);
      target_cols   <= SIZE_W'(1);
      channel_count <= CHCNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOURCE_ROWS:   source_rows   <= cfg_data;
        CFG_SOURCE_COLS:   source_cols   <= cfg_data;
        CFG_TARGET_ROWS:   target_rows   <= cfg_data;
        CFG_TARGET_COLS:   target_cols   <= cfg_data;
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[CHCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, large values saturate to the store
  logic [SIZE_W-1:0]  n_rows;
  logic [SIZE_W-1:0]  n_cols;
  logic [CHCNT_W-1:0] n_chans;
  logic [SIZE_W-1:0]  n_rows_m1;
  logic [SIZE_W-1:0]  n_cols_m1;

  always_comb begin
    if (source_rows == '0) begin
      n_rows = SIZE_W'(1);
    end else if (source_rows > SIZE_W'(MAX_ROWS)) begin
      n_rows = SIZE_W'(MAX_ROWS);
    end else begin
      n_rows = source_rows;
    end
    if (source_cols == '0) begin
      n_cols = SIZE_W'(1);
    end else if (source_cols > SIZE_W'(MAX_COLS)) begin
      n_cols = SIZE_W'(MAX_COLS);
    end else begin
      n_cols = source_cols;
    end
    if (channel_count == '0) begin
      n_chans = CHCNT_W'(1);
    end else if (channel_count > CHCNT_W'(MAX_CHANNELS)) begin
      n_chans = CHCNT_W'(MAX_CHANNELS);
    end else begin
      n_chans = channel_count;
    end
    n_rows_m1 = n_rows - SIZE_W'(1);
    n_cols_m1 = n_cols - SIZE_W'(1);
  end

  // --------------------------------------------------------------------------
  // ratio divider: ((n - 1) << FRACTION_BITS) / (target - 1), one bit a cycle,
  // row ratio first, then column ratio; restarted by every config write
  // --------------------------------------------------------------------------
  div_state_t           div_state;
  div_state_t           div_state_next;
  div_ctrl_t            div_ctrl;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [RATIO_W-1:0]   div_dvd;
  logic [RATIO_W-1:0]   div_quot;
  logic [SIZE_W-1:0]    div_rem;
  logic [SIZE_W-1:0]    div_den;
  logic [ROW_W-1:0]     div_num;
  logic [SIZE_W-1:0]    div_target;
  logic [SIZE_W:0]      div_trial;
  logic                 div_fit;
  logic [SIZE_W-1:0]    div_rem_next;
  logic [RATIO_W-1:0]   div_quot_next;
  logic [RATIO_W-1:0]   row_step;
  logic [RATIO_W-1:0]   col_step;

  always_comb begin
    div_state_next = div_state;
    unique case (div_state)
      DIV_IDLE:     div_state_next = DIV_IDLE;
      DIV_LOAD_ROW: div_state_next = DIV_RUN_ROW;
      DIV_RUN_ROW:  if (div_cnt == '0) div_state_next = DIV_LOAD_COL;
      DIV_LOAD_COL: div_state_next = DIV_RUN_COL;
      DIV_RUN_COL:  if (div_cnt == '0) div_state_next = DIV_IDLE;
      default:      div_state_next = DIV_IDLE;
    endcase
    if (cfg_we) begin
      div_state_next = DIV_LOAD_ROW;
    end
  end

  always_comb begin
    div_ctrl = '0;
    unique case (div_state)
      DIV_IDLE: ;
      DIV_LOAD_ROW: begin
        div_ctrl.load = 1'b1;
        div_ctrl.busy = 1'b1;
      end
      DIV_RUN_ROW: begin
        div_ctrl.step = 1'b1;
        div_ctrl.busy = 1'b1;
      end
      DIV_LOAD_COL: begin
        div_ctrl.load = 1'b1;
        div_ctrl.col  = 1'b1;
        div_ctrl.busy = 1'b1;
      end
      DIV_RUN_COL: begin
        div_ctrl.step = 1'b1;
        div_ctrl.col  = 1'b1;
        div_ctrl.busy = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_state <= DIV_IDLE;
    end else begin
      div_state <= div_state_next;
    end
  end

  // operand select and one restoring step
  always_comb begin
    div_num       = div_ctrl.col ? n_cols_m1[COL_W-1:0] : n_rows_m1[ROW_W-1:0];
    div_target    = div_ctrl.col ? target_cols : target_rows;
    div_trial     = {div_rem, div_dvd[RATIO_W-1]};
    div_fit       = div_trial >= {1'b0, div_den};
    div_rem_next  = div_fit ? SIZE_W'(div_trial - {1'b0, div_den}) : SIZE_W'(div_trial);
    div_quot_next = {div_quot[RATIO_W-2:0], div_fit};
  end

  always_ff @(posedge clk) begin
    if (div_ctrl.load) begin
      div_dvd  <= {div_num, FRACTION_BITS'(0)};
      div_den  <= div_target - SIZE_W'(1);
      div_rem  <= '0;
      div_quot <= '0;
      div_cnt  <= DIV_CNT_W'(RATIO_W - 1);
    end else if (div_ctrl.step) begin
      div_dvd  <= {div_dvd[RATIO_W-2:0], 1'b0};
      div_rem  <= div_rem_next;
      div_quot <= div_quot_next;
      div_cnt  <= div_cnt - DIV_CNT_W'(1);
    end
  end

  // a target of one (or zero) gives ratio zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_step <= '0;
      col_step <= '0;
    end else if (div_ctrl.step && div_cnt == '0) begin
      if (div_ctrl.col) begin
        col_step <= (div_target <= SIZE_W'(1)) ? '0 : div_quot_next;
      end else begin
        row_step <= (div_target <= SIZE_W'(1)) ? '0 : div_quot_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // front stage: accepted item waits here for the memory sequencer
  // --------------------------------------------------------------------------
  logic             s1_valid;
  item_t            s1_item;
  logic             s1_move;
  logic             item_take;
  logic [CNT_W-1:0] credit_cnt;
  logic             credit_ok;
  logic             s2_valid;
  logic             s2_done;
  logic             s2_free;

  assign credit_ok  = credit_cnt < CNT_W'(OUT_DEPTH);
  assign s2_free    = !s2_valid || s2_done;
  assign s1_move    = s1_valid && s2_free && (s1_item.opcode == OP_LOAD || credit_ok);
  assign item_stall = div_ctrl.busy || cfg_we || (s1_valid && !s1_move);
  assign item_take  = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_item <= item;
    end
  end

  // --------------------------------------------------------------------------
  // sequencer stage: owns the frame memory port
  // scaled source position is formed on the way in
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]         pos_r;
  logic [POS_W-1:0]         pos_c;
  logic [OP_W-1:0]          s2_op;
  pos_t                     s2_pos;
  logic [PIX_W-1:0]         s2_pix;
  logic [INT_W-1:0]         s2_xr;
  logic [INT_W-1:0]         s2_yc;
  logic [FRACTION_BITS-1:0] s2_fa;
  logic [FRACTION_BITS-1:0] s2_fb;
  phase_t                   s2_phase;

  assign pos_r   = POS_W'(row_step) * POS_W'(s1_item.row_index);
  assign pos_c   = POS_W'(col_step) * POS_W'(s1_item.col_index);
  assign s2_done = s2_valid && (s2_op == OP_LOAD || s2_phase == PH_BOTTOM_RIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_phase <= PH_TOP_LEFT;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
      s2_phase <= PH_TOP_LEFT;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end else if (s2_valid) begin
      s2_phase <= phase_t'(s2_phase + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_op      <= s1_item.opcode;
      s2_pos.row <= s1_item.row_index;
      s2_pos.col <= s1_item.col_index;
      s2_pos.ch  <= s1_item.channel_index;
      s2_pix     <= s1_item.pixel_in;
      s2_xr      <= pos_r[POS_W-1:FRACTION_BITS];
      s2_yc      <= pos_c[POS_W-1:FRACTION_BITS];
      s2_fa      <= pos_r[FRACTION_BITS-1:0];
      s2_fb      <= pos_c[FRACTION_BITS-1:0];
    end
  end

  // neighbour of the current phase and its bounds check
  logic            nb_dr;
  logic            nb_dc;
  logic [NB_W-1:0] nb_row;
  logic [NB_W-1:0] nb_col;
  logic            nb_inside;

  always_comb begin
    case (s2_phase)
      PH_TOP_LEFT:     {nb_dr, nb_dc} = 2'b00;
      PH_TOP_RIGHT:    {nb_dr, nb_dc} = 2'b01;
      PH_BOTTOM_LEFT:  {nb_dr, nb_dc} = 2'b10;
      PH_BOTTOM_RIGHT: {nb_dr, nb_dc} = 2'b11;
      default:         {nb_dr, nb_dc} = 2'b00;
    endcase
    nb_row    = NB_W'(s2_xr) + NB_W'(nb_dr);
    nb_col    = NB_W'(s2_yc) + NB_W'(nb_dc);
    nb_inside = (nb_row < NB_W'(n_rows)) && (nb_col < NB_W'(n_cols)) &&
                (s2_pos.ch < n_chans);
  end

  // --------------------------------------------------------------------------
  // frame memory: one port, read data registered; accesses stay in item
  // order so a request always sees every earlier load
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0]    frame_mem [FRAME_DEPTH];
  logic [PIX_W-1:0]    mem_rdata;
  logic [FRAME_AW-1:0] mem_addr;
  logic                mem_we;

  // a load to a channel beyond the store is dropped
  assign mem_we   = s2_valid && s2_op == OP_LOAD && s2_pos.ch < CH_W'(MAX_CHANNELS);
  assign mem_addr = (s2_op == OP_LOAD) ?
                    frame_addr(s2_pos.row, s2_pos.col, s2_pos.ch) :
                    frame_addr(nb_row[ROW_W-1:0], nb_col[COL_W-1:0], s2_pos.ch);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_addr] <= s2_pix;
    end
    mem_rdata <= frame_mem[mem_addr];
  end

  // --------------------------------------------------------------------------
  // read return: tag, mask neighbours outside the source, gather four bytes
  // --------------------------------------------------------------------------
  logic                     rd_valid;
  phase_t                   rd_phase;
  logic                     rd_inside;
  logic [PIX_W-1:0]         rd_pix;
  pos_t                     m_pos;
  logic [FRACTION_BITS-1:0] m_fa;
  logic [FRACTION_BITS-1:0] m_fb;
  logic [PIX_W-1:0]         hold_tl;
  logic [PIX_W-1:0]         hold_tr;
  logic [PIX_W-1:0]         hold_bl;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= s2_valid && s2_op == OP_REQUEST;
    end
  end

  always_ff @(posedge clk) begin
    rd_phase  <= s2_phase;
    rd_inside <= nb_inside;
    if (s2_valid && s2_op == OP_REQUEST && s2_phase == PH_BOTTOM_RIGHT) begin
      m_pos <= s2_pos;
      m_fa  <= s2_fa;
      m_fb  <= s2_fb;
    end
  end

  assign rd_pix = rd_inside ? mem_rdata : '0;

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      case (rd_phase)
        PH_TOP_LEFT:    hold_tl <= rd_pix;
        PH_TOP_RIGHT:   hold_tr <= rd_pix;
        PH_BOTTOM_LEFT: hold_bl <= rd_pix;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // interpolation pipeline: weights, weighted terms, pair sums, round
  // --------------------------------------------------------------------------
  logic                        c1_valid;
  logic [3:0][PIX_W-1:0]       c1_pix;
  logic [FRACTION_BITS-1:0]    c1_fa;
  logic [FRACTION_BITS-1:0]    c1_fb;
  pos_t                        c1_pos;
  logic [FW1_W-1:0]            wa0;
  logic [FW1_W-1:0]            wb0;
  logic                        c2_valid;
  logic [3:0][WGT_W-1:0]       c2_w;
  logic [3:0][PIX_W-1:0]       c2_pix;
  pos_t                        c2_pos;
  logic                        c3_valid;
  logic [3:0][TERM_W-1:0]      c3_t;
  pos_t                        c3_pos;
  logic                        c4_valid;
  logic [SUM_W-1:0]            c4_s01;
  logic [SUM_W-1:0]            c4_s23;
  pos_t                        c4_pos;
  logic [SUM_W-1:0]            fin_sum;
  logic [VAL_W-1:0]            fin_val;
  logic [PIX_W-1:0]            fin_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
      c2_valid <= 1'b0;
      c3_valid <= 1'b0;
      c4_valid <= 1'b0;
    end else begin
      c1_valid <= rd_valid && rd_phase == PH_BOTTOM_RIGHT;
      c2_valid <= c1_valid;
      c3_valid <= c2_valid;
      c4_valid <= c3_valid;
    end
  end

  // full unit and the complementary column weight, one full unit minus the fraction
  assign wa0 = FW1_W'(1) << FRACTION_BITS;
  assign wb0 = (FW1_W'(1) << FRACTION_BITS) - FW1_W'(c1_fb);

  always_ff @(posedge clk) begin
    c1_pix <= {rd_pix, hold_bl, hold_tr, hold_tl};
    c1_fa  <= m_fa;
    c1_fb  <= m_fb;
    c1_pos <= m_pos;

    c2_w[0] <= WGT_W'(wa0 - FW1_W'(c1_fa)) * WGT_W'(wb0);
    c2_w[1] <= WGT_W'(wa0 - FW1_W'(c1_fa)) * WGT_W'(c1_fb);
    c2_w[2] <= WGT_W'(c1_fa) * WGT_W'(wb0);
    c2_w[3] <= WGT_W'(c1_fa) * WGT_W'(c1_fb);
    c2_pix  <= c1_pix;
    c2_pos  <= c1_pos;

    for (int i = 0; i < 4; i++) begin
      c3_t[i] <= TERM_W'(c2_w[i]) * TERM_W'(c2_pix[i]);
    end
    c3_pos <= c2_pos;

    c4_s01 <= SUM_W'(c3_t[0]) + SUM_W'(c3_t[1]);
    c4_s23 <= SUM_W'(c3_t[2]) + SUM_W'(c3_t[3]);
    c4_pos <= c3_pos;
  end

  // round half up, then saturate to a byte
  always_comb begin
    fin_sum = c4_s01 + c4_s23 + (SUM_W'(1) << (2 * FRACTION_BITS - 1));
    fin_val = fin_sum[SUM_W-1:2*FRACTION_BITS];
    if (fin_val > VAL_W'((1 << PIX_W) - 1)) begin
      fin_pix = '1;
    end else begin
      fin_pix = fin_val[PIX_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // result queue and request credits
  // --------------------------------------------------------------------------
  result_t           out_fifo [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr;
  logic [OUT_AW-1:0] rd_ptr;
  logic [CNT_W-1:0]  fifo_cnt;
  logic              fifo_pop;
  logic              req_issue;

  assign result_valid = fifo_cnt != '0;
  assign result       = out_fifo[rd_ptr];
  assign fifo_pop     = result_valid && !result_stall;
  assign req_issue    = s1_move && s1_item.opcode == OP_REQUEST;

  always_ff @(posedge clk) begin
    if (c4_valid) begin
      out_fifo[wr_ptr] <= '{pixel_out: fin_pix, out_row: c4_pos.row,
                            out_col: c4_pos.col, out_channel: c4_pos.ch};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_cnt   <= '0;
      credit_cnt <= '0;
    end else begin
      if (c4_valid) begin
        wr_ptr <= wr_ptr + OUT_AW'(1);
      end
      if (fifo_pop) begin
        rd_ptr <= rd_ptr + OUT_AW'(1);
      end
      case ({c4_valid, fifo_pop})
        2'b10:   fifo_cnt <= fifo_cnt + CNT_W'(1);
        2'b01:   fifo_cnt <= fifo_cnt - CNT_W'(1);
        default: fifo_cnt <= fifo_cnt;
      endcase
      // a credit is held from issue until the result transfer
      case ({req_issue, fifo_pop})
        2'b10:   credit_cnt <= credit_cnt + CNT_W'(1);
        2'b01:   credit_cnt <= credit_cnt - CNT_W'(1);
        default: credit_cnt <= credit_cnt;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit_cnt <= CNT_W'(OUT_DEPTH))
    else $error("request credits exceed result queue depth");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    c4_valid |-> fifo_cnt < CNT_W'(OUT_DEPTH))
    else $error("result written into a full queue");

  a_queue_covered: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= credit_cnt)
    else $error("queued results without matching credits");

  a_cfg_blocks_items: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> item_stall)
    else $error("item taken while ratios are being recomputed");
`endif

endmodule

FILE: test/bilinear_image_resize_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_image_resize_test
// Self-checking bench for the bilinear scaler: source bytes are loaded into
// the frame store, output pixels are requested and each returned byte is
// compared against an interpolation computed inside the bench.
// ----------------------------------------------------------------------------
module bilinear_image_resize_test;
  import bir_pkg::*;

  // clock, reset and dut ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;

  // size registers as the scaler holds them (reset value is one everywhere)
  logic [SIZE_W-1:0]  src_rows = SIZE_W'(1);
  logic [SIZE_W-1:0]  src_cols = SIZE_W'(1);
  logic [SIZE_W-1:0]  tgt_rows = SIZE_W'(1);
  logic [SIZE_W-1:0]  tgt_cols = SIZE_W'(1);
  logic [CHCNT_W-1:0] chan_count = CHCNT_W'(1);

  // frame store contents as seen by transfers accepted so far
  logic [PIX_W-1:0] frame_model [int];
  // entries the stimulus has already loaded, so no request reads an unwritten byte
  bit               loaded [int];

  item_t   pending_items [$];
  result_t expected_pixels [$];

  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 70;
  bit          long_hold_go = 1'b0;
  logic        result_hold = 1'b0;

  int unsigned error_count = 0;
  int unsigned loads_sent = 0;
  int unsigned requests_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned setting_count = 0;

  bilinear_image_resize DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // interpolation arithmetic
  // ---------------------------------------------------------------------------

  // sizes saturate to 1..top, zero acts as one
  function automatic longint unsigned eff_size(longint unsigned v, longint unsigned top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // fixed point step per output index, zero when the target has a single line
  function automatic longint unsigned scale_ratio(longint unsigned src, longint unsigned dst);
    if (dst <= 1) return 0;
    return ((src - 1) << FRACTION_BITS) / (dst - 1);
  endfunction

  function automatic int store_addr(longint unsigned r, longint unsigned c, longint unsigned ch);
    return int'((r * MAX_COLS + c) * MAX_CHANNELS + ch);
  endfunction

  // neighbours beyond the effective source read as zero
  function automatic longint unsigned source_byte(longint unsigned r, longint unsigned c,
                                                  longint unsigned ch, longint unsigned nr,
                                                  longint unsigned nc, longint unsigned nch);
    int addr;
    if (r >= nr || c >= nc || ch >= nch) return 0;
    addr = store_addr(r, c, ch);
    return frame_model.exists(addr) ? longint'(frame_model[addr]) : 0;
  endfunction

  function automatic logic [PIX_W-1:0] interpolate(logic [ROW_W-1:0] row,
                                                   logic [COL_W-1:0] col,
                                                   logic [CH_W-1:0]  ch);
    longint unsigned one = 64'd1 << FRACTION_BITS;
    longint unsigned nr, nc, nch, pos_r, pos_c, xr, yc, fa, fb, wa, wb, sum, val;
    nr    = eff_size(src_rows, MAX_ROWS);
    nc    = eff_size(src_cols, MAX_COLS);
    nch   = eff_size(chan_count, MAX_CHANNELS);
    pos_r = scale_ratio(nr, tgt_rows) * row;
    pos_c = scale_ratio(nc, tgt_cols) * col;
    xr    = pos_r >> FRACTION_BITS;
    yc    = pos_c >> FRACTION_BITS;
    fa    = pos_r & (one - 1);
    fb    = pos_c & (one - 1);
    wa    = one - fa;
    wb    = one - fb;
    sum   = wa * wb * source_byte(xr,     yc,     ch, nr, nc, nch)
          + wa * fb * source_byte(xr,     yc + 1, ch, nr, nc, nch)
          + fa * wb * source_byte(xr + 1, yc,     ch, nr, nc, nch)
          + fa * fb * source_byte(xr + 1, yc + 1, ch, nr, nc, nch);
    // round half up, then saturate
    val = (sum + (64'd1 << (2 * FRACTION_BITS - 1))) >> (2 * FRACTION_BITS);
    return (val > 255) ? PIX_W'(255) : PIX_W'(val);
  endfunction

  // update the store or queue the expected pixel for one accepted transfer
  task automatic record_transfer(item_t it);
    result_t exp_px;
    if (it.opcode == OP_LOAD) begin
      // a load into a channel the store does not have is dropped
      if (it.channel_index < MAX_CHANNELS)
        frame_model[store_addr(it.row_index, it.col_index, it.channel_index)] = it.pixel_in;
      loads_sent++;
    end else begin
      exp_px.pixel_out   = interpolate(it.row_index, it.col_index, it.channel_index);
      exp_px.out_row     = it.row_index;
      exp_px.out_col     = it.col_index;
      exp_px.out_channel = it.channel_index;
      expected_pixels.push_back(exp_px);
      requests_sent++;
    end
  endtask

  task automatic check_pixel(result_t got);
    result_t exp_px;
    if (expected_pixels.size() == 0) begin
      $error("pixel for row %0d col %0d arrived with none outstanding", got.out_row,
             got.out_col);
      error_count++;
    end else begin
      exp_px = expected_pixels.pop_front();
      pixels_checked++;
      if (got.pixel_out !== exp_px.pixel_out) begin
        $error("pixel_out expected %0d actual %0d", exp_px.pixel_out, got.pixel_out);
        error_count++;
      end
      if (got.out_row !== exp_px.out_row) begin
        $error("out_row expected %0d actual %0d", exp_px.out_row, got.out_row);
        error_count++;
      end
      if (got.out_col !== exp_px.out_col) begin
        $error("out_col expected %0d actual %0d", exp_px.out_col, got.out_col);
        error_count++;
      end
      if (got.out_channel !== exp_px.out_channel) begin
        $error("out_channel expected %0d actual %0d", exp_px.out_channel, got.out_channel);
        error_count++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // item driver: holds a stalled transfer, otherwise offers the next pending
  // item unless it rolls an idle cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) record_transfer(item);
      if (item_valid && item_stall) begin
        // payload and valid stay put until the transfer happens
      end else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: checks each transfer and draws the next stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_pixel(result);
      result_stall <= result_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // one long receiver hold so the result queue fills and the item side backs up
  initial begin
    wait (long_hold_go);
    @(posedge clk);
    result_hold <= 1'b1;
    repeat (300) @(posedge clk);
    result_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // block until every item is across and every pixel is back, then let
  // the pipeline settle
  task automatic wait_drained();
    while (pending_items.size() != 0 || item_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    case (idx)
      CFG_SOURCE_ROWS:   src_rows = SIZE_W'(value);
      CFG_SOURCE_COLS:   src_cols = SIZE_W'(value);
      CFG_TARGET_ROWS:   tgt_rows = SIZE_W'(value);
      CFG_TARGET_COLS:   tgt_cols = SIZE_W'(value);
      CFG_CHANNEL_COUNT: chan_count = CHCNT_W'(value);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(int unsigned sr, int unsigned sc, int unsigned tr,
                           int unsigned tc, int unsigned chn);
    write_reg(CFG_SOURCE_ROWS, sr);
    write_reg(CFG_SOURCE_COLS, sc);
    write_reg(CFG_TARGET_ROWS, tr);
    write_reg(CFG_TARGET_COLS, tc);
    write_reg(CFG_CHANNEL_COUNT, chn);
    setting_count++;
  endtask

  task automatic push_load(int unsigned row, int unsigned col, int unsigned ch,
                           int unsigned px);
    item_t it;
    it.opcode        = OP_LOAD;
    it.row_index     = ROW_W'(row);
    it.col_index     = COL_W'(col);
    it.channel_index = CH_W'(ch);
    it.pixel_in      = PIX_W'(px);
    pending_items.push_back(it);
    if (ch < MAX_CHANNELS) loaded[store_addr(row, col, ch)] = 1'b1;
  endtask

  // a request, preceded by loads of any in-source neighbour not yet written
  task automatic add_request(int unsigned row, int unsigned col, int unsigned ch,
                             int unsigned px);
    longint unsigned nr, nc, nch, base_r, base_c, rr, cc;
    item_t it;
    nr     = eff_size(src_rows, MAX_ROWS);
    nc     = eff_size(src_cols, MAX_COLS);
    nch    = eff_size(chan_count, MAX_CHANNELS);
    base_r = (scale_ratio(nr, tgt_rows) * row) >> FRACTION_BITS;
    base_c = (scale_ratio(nc, tgt_cols) * col) >> FRACTION_BITS;
    for (int dr = 0; dr < 2; dr++) begin
      for (int dc = 0; dc < 2; dc++) begin
        rr = base_r + dr;
        cc = base_c + dc;
        if (rr < nr && cc < nc && ch < nch && !loaded.exists(store_addr(rr, cc, ch)))
          push_load(32'(rr), 32'(cc), ch, $urandom_range(255));
      end
    end
    it.opcode        = OP_REQUEST;
    it.row_index     = ROW_W'(row);
    it.col_index     = COL_W'(col);
    it.channel_index = CH_W'(ch);
    it.pixel_in      = PIX_W'(px);
    pending_items.push_back(it);
  endtask

  // raster load of the whole effective source with fresh random bytes
  task automatic preload_source();
    for (int r = 0; r < eff_size(src_rows, MAX_ROWS); r++)
      for (int c = 0; c < eff_size(src_cols, MAX_COLS); c++)
        for (int ch = 0; ch < eff_size(chan_count, MAX_CHANNELS); ch++)
          push_load(r, c, ch, $urandom_range(255));
  endtask

  // mostly in-range requests and loads, the rest anywhere in the index space
  task automatic random_traffic(int unsigned n);
    int unsigned nr, nc, nch, span_r, span_c, pick;
    nr     = 32'(eff_size(src_rows, MAX_ROWS));
    nc     = 32'(eff_size(src_cols, MAX_COLS));
    nch    = 32'(eff_size(chan_count, MAX_CHANNELS));
    span_r = 32'(eff_size(tgt_rows, MAX_ROWS));
    span_c = 32'(eff_size(tgt_cols, MAX_COLS));
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 55)
        add_request($urandom_range(span_r - 1), $urandom_range(span_c - 1),
                    $urandom_range(nch - 1), $urandom_range(255));
      else if (pick < 75)
        push_load($urandom_range(nr - 1), $urandom_range(nc - 1), $urandom_range(nch - 1),
                  $urandom_range(255));
      else if (pick < 88)
        // anywhere in the index space, possibly outside the target or an absent channel
        add_request($urandom_range(1023), $urandom_range(1023), $urandom_range(3),
                    $urandom_range(255));
      else
        // anywhere in the index space, channel three is dropped by the store
        push_load($urandom_range(1023), $urandom_range(1023), $urandom_range(3),
                  $urandom_range(255));
    end
  endtask

  task automatic run_phase(int unsigned sr, int unsigned sc, int unsigned tr,
                           int unsigned tc, int unsigned chn, int unsigned n,
                           bit preload, bit hold, bit pause);
    wait_drained();
    configure(sr, sc, tr, tc, chn);
    if (preload) preload_source();
    if (hold) long_hold_go = 1'b1;
    if (pause) begin
      // sender stops halfway until every outstanding pixel is back
      random_traffic(n / 2);
      wait_drained();
      random_traffic(n - n / 2);
    end else begin
      random_traffic(n);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver heavily
    send_idle_pct = 19;
    recv_idle_pct = 70;

    // reset sizes: one by one source, every request reads the top-left byte
    push_load(0, 0, 0, 255);
    add_request(0, 0, 0, 0);
    push_load(1023, 1023, 2, 0);       // stored although beyond the source
    push_load(1023, 1023, 3, 255);     // channel the store lacks, dropped
    add_request(1023, 1023, 3, 255);   // absent channel reads zero
    add_request(5, 7, 0, 0);           // outside the target, zero ratio
    wait_drained();

    // two by two source to three by three: center pixel rounds half up
    configure(2, 2, 3, 3, 1);
    push_load(0, 0, 0, 0);
    push_load(0, 1, 0, 255);
    push_load(1, 0, 0, 255);
    push_load(1, 1, 0, 0);
    add_request(1, 1, 0, 0);
    add_request(2, 2, 0, 0);
    add_request(0, 1, 0, 0);
    add_request(1, 0, 1, 0);

    run_phase(4, 5, 7, 9, 3, 160, 1'b1, 1'b1, 1'b0);
    run_phase(2, 2, 1024, 1024, 1, 150, 1'b1, 1'b0, 1'b0);
    run_phase(1024, 1, 3, 1, 1, 150, 1'b0, 1'b0, 1'b0);

    // now the receiver is the quick side
    wait_drained();
    send_idle_pct = 70;
    recv_idle_pct = 19;
    run_phase(1, 1024, 1, 1024, 2, 100, 1'b0, 1'b0, 1'b0);
    // zero and oversized register values saturate
    run_phase(0, 2047, 5, 0, 0, 150, 1'b0, 1'b0, 1'b1);
    run_phase(2047, 3, 1, 2, 3, 150, 1'b0, 1'b0, 1'b0);
    run_phase(5, 6, 3, 4, 2, 150, 1'b1, 1'b0, 1'b0);

    // full rate on both sides
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(3, 3, 3, 3, 1, 120, 1'b1, 1'b0, 1'b0);
    repeat (4)
      run_phase($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(16, 1),
                $urandom_range(16, 1), $urandom_range(3, 1), 100, 1'b1, 1'b0, 1'b0);

    wait_drained();
    $display("covered %0d source loads and %0d pixel requests over %0d size settings",
             loads_sent, requests_sent, setting_count);
    $display("%0d interpolated pixels checked", pixels_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
rtl/bir_pkg.sv
rtl/bilinear_image_resize.sv
test/bilinear_image_resize_test.sv
